>>> sv/leaky_bucket_queue_shaper_assert.svh
// ----------------------------------------------------------------------------
// Leaky-bucket queue shaper assertion macros
// Shared property macros for the port-level checker of the shaper.
// ----------------------------------------------------------------------------
`ifndef LEAKY_BUCKET_QUEUE_SHAPER_ASSERT_SVH
`define LEAKY_BUCKET_QUEUE_SHAPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBQS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lbqs_pkg.sv
// ----------------------------------------------------------------------------
// Leaky-bucket queue shaper package
// Sizes, result codes, register indexes and shared types of the shaper.
// ----------------------------------------------------------------------------
package lbqs_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Configuration port geometry.
    localparam int CFG_W  = 5;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Result codes.
    localparam logic [1:0] OC_ACCEPTED  = 2'd0;
    localparam logic [1:0] OC_REJECTED  = 2'd1;
    localparam logic [1:0] OC_RELEASED  = 2'd2;
    localparam logic [1:0] OC_IDLE_TICK = 2'd3;

    // Register indexes, taken from the word address.
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_DRAIN    = 1'b1;

    // Write request to the key store.
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     addr;
        logic [KEY_WIDTH-1:0] data;
    } t_ram_wr;

endpackage

>>> sv/leaky_bucket_queue_shaper.sv
// ----------------------------------------------------------------------------
// Leaky-bucket queue shaper
// Bounded FIFO of request keys that admits adds up to a capacity and
// releases queued keys in order on each tick.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An add keeps busy
// high for one cycle, so no new item is taken while an add is in progress.
// A tick keeps busy high through the tick state and one drain state per key
// released, since the sequencer drains one key per cycle through the single
// read port of the key store. Each result is registered in the pending
// entry and then in the output registers; a released key is read from the
// store's registered port alongside its pending entry, and the keys of one
// tick follow in consecutive cycles. Results appear in order on o_valid for
// exactly one cycle each and cannot be held off by the receiver.
// Configuration is to be written only while the block is idle with no
// result outstanding.
// ----------------------------------------------------------------------------
module leaky_bucket_queue_shaper import lbqs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Command channel.
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_req_type,
    input  logic [KEY_WIDTH-1:0] i_request_key,
    // Result channel.
    output logic                 o_valid,
    output logic [1:0]           o_outcome,
    output logic [KEY_WIDTH-1:0] o_released_key,
    output logic [CNT_W-1:0]     o_free_slots,
    output logic                 o_last,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ADD   = 2'd1;
    localparam logic [1:0] S_TICK  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [1:0]       outcome;
        logic [CNT_W-1:0] free;
        logic             last;
        logic             from_ram;
    } t_pend;

    logic [1:0]           r_state, n_state;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [IDX_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]     r_occ, n_occ;
    logic [CNT_W-1:0]     r_remain, n_remain;
    logic [CFG_W-1:0]     r_cap;
    logic [CFG_W-1:0]     r_drain;
    t_pend                r_pend, n_pend;

    logic [CNT_W-1:0]     eff_cap;
    logic [CNT_W-1:0]     lim;
    logic [CNT_W-1:0]     occ_dec;
    logic [CNT_W-1:0]     sub_opnd;
    logic [CNT_W:0]       sub_res;
    logic                 sub_pos;
    logic [CNT_W-1:0]     free_val;
    logic [CNT_W:0]       tail_sum;
    logic [IDX_W-1:0]     tail;
    logic [IDX_W-1:0]     head_inc;
    logic                 drain_last;
    logic                 cfg_wr;
    t_ram_wr              ram_wr;
    logic [KEY_WIDTH-1:0] ram_rdata;

    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Effective limits, saturated at the queue depth.
    always_comb begin
        eff_cap = (r_cap > CFG_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(r_cap);
        lim     = (r_drain > CFG_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(r_drain);
    end

    // Shared subtract-compare unit: capacity minus an occupancy operand.
    always_comb begin
        occ_dec  = r_occ - CNT_W'(1);
        sub_opnd = (r_state == S_DRAIN) ? occ_dec : r_occ;
        sub_res  = {1'b0, eff_cap} - {1'b0, sub_opnd};
        sub_pos  = !sub_res[CNT_W] && (sub_res != '0);
        free_val = sub_res[CNT_W] ? '0 : sub_res[CNT_W-1:0];
    end

    // Ring pointers.
    always_comb begin
        tail_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_occ);
        if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            tail = IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH));
        end else begin
            tail = tail_sum[IDX_W-1:0];
        end
        head_inc   = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
        drain_last = (r_remain == CNT_W'(1)) || (r_occ == CNT_W'(1));
    end

    // Key store write on an admitted add.
    always_comb begin
        ram_wr.en   = (r_state == S_ADD) && sub_pos;
        ram_wr.addr = tail;
        ram_wr.data = r_key;
    end

    lbqs_key_ram u_key_ram (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_head   = r_head;
        n_occ    = r_occ;
        n_remain = r_remain;
        n_pend   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key   = i_request_key;
                    n_state = i_req_type ? S_TICK : S_ADD;
                end
            end
            S_ADD: begin
                n_pend.valid = 1'b1;
                n_pend.last  = 1'b1;
                if (sub_pos) begin
                    n_occ          = r_occ + CNT_W'(1);
                    n_pend.outcome = OC_ACCEPTED;
                    n_pend.free    = sub_res[CNT_W-1:0] - CNT_W'(1);
                end else begin
                    n_pend.outcome = OC_REJECTED;
                    n_pend.free    = '0;
                end
                n_state = S_IDLE;
            end
            S_TICK: begin
                if ((lim == '0) || (r_occ == '0)) begin
                    n_pend.valid   = 1'b1;
                    n_pend.outcome = OC_IDLE_TICK;
                    n_pend.free    = free_val;
                    n_pend.last    = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_remain = lim;
                    n_state  = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_head          = head_inc;
                n_occ           = occ_dec;
                n_remain        = r_remain - CNT_W'(1);
                n_pend.valid    = 1'b1;
                n_pend.outcome  = OC_RELEASED;
                n_pend.free     = free_val;
                n_pend.last     = drain_last;
                n_pend.from_ram = 1'b1;
                if (drain_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_occ    <= '0;
            r_remain <= '0;
            r_pend   <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_remain <= n_remain;
            r_pend   <= n_pend;
            o_valid  <= r_pend.valid;
        end
    end

    // Payload registers; the result beat takes its key from the store or the echo.
    always_ff @(posedge i_clk) begin
        r_key          <= n_key;
        o_outcome      <= r_pend.outcome;
        o_free_slots   <= r_pend.free;
        o_last         <= r_pend.last;
        o_released_key <= r_pend.from_ram ? ram_rdata : r_key;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CFG_W'(QUEUE_DEPTH);
            r_drain <= CFG_W'(1);
        end else if (cfg_wr) begin
            if (paddr[ADDR_W-1:2] == REG_CAPACITY) begin
                r_cap <= pwdata[CFG_W-1:0];
            end else begin
                r_drain <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Register read-back.
    always_comb begin
        if (paddr[ADDR_W-1:2] == REG_DRAIN) begin
            prdata = DATA_W'(r_drain);
        end else begin
            prdata = DATA_W'(r_cap);
        end
    end

endmodule

>>> sv/lbqs_key_ram.sv
// ----------------------------------------------------------------------------
// Leaky-bucket queue shaper key store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbqs_key_ram import lbqs_pkg::*; (
    input  logic                 i_clk,
    input  t_ram_wr              i_wr,
    input  logic [IDX_W-1:0]     i_raddr,
    output logic [KEY_WIDTH-1:0] o_rdata
);

    logic [KEY_WIDTH-1:0] r_mem [QUEUE_DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/lbqs_checker.sv
// ----------------------------------------------------------------------------
// Leaky-bucket queue shaper checker
// Port-level assertions on the shaper, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "leaky_bucket_queue_shaper_assert.svh"

module lbqs_checker import lbqs_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic [1:0]           o_outcome,
    input logic [CNT_W-1:0]     o_free_slots,
    input logic                 o_last
);

    // An accepted command makes the block busy on the next cycle.
    `LBQS_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "busy not raised after a command beat")

    // Only released-key beats may be followed by more beats of the same item.
    `LBQS_ASSERT_NOW(a_single_beat_last, i_clk, i_rst_n, o_valid && (o_outcome != OC_RELEASED), o_last, "single-beat result without last")

    // A rejected add means the queue has no free slot.
    `LBQS_ASSERT_NOW(a_reject_no_free, i_clk, i_rst_n, o_valid && (o_outcome == OC_REJECTED), o_free_slots == '0, "rejected add with free slots")

    // Released keys of one tick come out in consecutive cycles.
    `LBQS_ASSERT_NEXT(a_drain_burst, i_clk, i_rst_n, o_valid && (o_outcome == OC_RELEASED) && !o_last, o_valid && (o_outcome == OC_RELEASED), "gap inside a drain burst")

endmodule

bind leaky_bucket_queue_shaper lbqs_checker u_lbqs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_outcome    (o_outcome),
    .o_free_slots (o_free_slots),
    .o_last       (o_last)
);
